[hdl/assert_macros.svh]
// assertion helpers, included by rational_arith_unit_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rau_pkg.sv]
package rau_pkg;

    // operand width default, field widths of the item
    localparam int WIDTH_DEFAULT = 32;
    localparam int FIELD_W       = 32;
    localparam int DEN_W         = 31;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    // stream packing
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 72;
    localparam int DEN_LSB    = FIELD_W;
    localparam int EQ_BIT     = FIELD_W + DEN_W;
    localparam int STATUS_LSB = EQ_BIT + 1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_EQ  = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DIV0 = 2'd1,
        STATUS_OVF  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

[hdl/rau_unit.sv]
module rau_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
    input  logic [WIDTH-1:0]   mul_a,
    input  logic [WIDTH-1:0]   mul_b,
    output logic [2*WIDTH-1:0] mul_p,
    input  logic [2*WIDTH:0]   sub_a,
    input  logic [2*WIDTH:0]   sub_b,
    output logic [2*WIDTH:0]   sub_diff,
    output logic               sub_borrow
);

    logic [2*WIDTH+1:0] diff_full;

    // unsigned magnitude multiplier, full double-width product
    assign mul_p = (2*WIDTH)'(mul_a) * (2*WIDTH)'(mul_b);

    // shared subtractor with borrow out
    assign diff_full  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_diff   = diff_full[2*WIDTH:0];
    assign sub_borrow = diff_full[2*WIDTH+1];

endmodule

[hdl/rational_arith_unit_core.sv]
// Exact fraction arithmetic: each input item carries an op code and two fractions
// a_num/a_den and b_num/b_den (the low WIDTH bits of each field, two's complement) and
// yields one item with the reduced result, the equality flag and a status (ok, divide by
// zero, overflow). Items are handled one at a time; s_tready is high only while the
// sequencer is idle, and a finished item can wait in the output register while the next
// one is taken. Work per item on the one shared multiplier and subtractor: two or three
// multiplies and one combine step (negation skips both), then a binary gcd on the
// double-width numerator and denominator, then two restoring divisions by the gcd.
// Equality, bad op codes and zero denominators finish without the gcd and divisions.
`include "assert_macros.svh"

module rational_arith_unit_core #(
    parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero pad
    input  logic [rau_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // res_num[31:0], res_den[62:32], equal[63], status[65:64], zero pad
    output logic [rau_pkg::M_TDATA_W-1:0] m_tdata
);

    import rau_pkg::*;

    localparam int DW = 2 * WIDTH;
    localparam int CW = $clog2(DW);
    localparam int KW = $clog2(DW);
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);
    localparam logic [DW-1:0] ONE      = DW'(1);
    localparam logic [DW-1:0] HALF     = ONE << (WIDTH - 1);
    localparam logic [1:0] IX_AN = 2'd0;
    localparam logic [1:0] IX_AD = 2'd1;
    localparam logic [1:0] IX_BN = 2'd2;
    localparam logic [1:0] IX_BD = 2'd3;

    state_t state_reg, state_next;

    logic [3:0][WIDTH-1:0] opnd_mag_reg, opnd_mag_next;
    logic [3:0]            opnd_neg_reg, opnd_neg_next;
    op_t                   op_reg, op_next;
    logic [DW-1:0]         p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [DW-1:0]         n_reg, n_next, d_reg, d_next;
    logic                  neg_reg, neg_next;
    logic [DW-1:0]         gx_reg, gx_next, gy_reg, gy_next, g_reg, g_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [DW-1:0]         q_reg, q_next, rem_reg, rem_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [FIELD_W-1:0]    pend_num_reg, pend_num_next;
    logic [DEN_W-1:0]      pend_den_reg, pend_den_next;
    logic                  pend_eq_reg, pend_eq_next;
    status_t               pend_status_reg, pend_status_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // input decode
    logic [3:0][WIDTH-1:0] in_val, in_mag;
    logic [3:0]            in_neg;
    op_t                   in_op;
    logic                  in_accept, in_bad, in_div0;

    // shared unit hookup
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [DW-1:0]    mul_p;
    logic [DW:0]      sub_a, sub_b, sub_diff, sub_neg;
    logic             sub_borrow;

    // combine, gcd and divide helpers
    logic          s0, s1;
    logic [DW-1:0] comb_n, comb_d;
    logic          comb_nneg, comb_dneg, comb_eq;
    logic [DW-1:0] gcd_g;
    logic          gcd_done;
    logic [DW:0]   rem_shift;
    logic [DW-1:0] div_q, div_rem;
    logic          div_last;
    logic          fin_neg, fin_fits;
    logic [WIDTH-1:0] fin_num;
    logic          out_load;

    // split the input item into sign and magnitude
    assign in_op     = op_t'(s_tdata[OP_W-1:0]);
    assign in_accept = s_tvalid && s_tready;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_val[i] = s_tdata[OP_W + FIELD_W*i +: WIDTH];
            in_neg[i] = in_val[i][WIDTH-1];
            in_mag[i] = in_neg[i] ? (WIDTH)'(-in_val[i]) : in_val[i];
        end
    end
    assign in_bad  = !(in_op inside {[OP_ADD:OP_EQ]});
    assign in_div0 = (in_mag[IX_AD] == '0) || (in_op != OP_NEG && in_mag[IX_BD] == '0);

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                mul_a = opnd_mag_reg[IX_AN];
                mul_b = (op_reg == OP_MUL) ? opnd_mag_reg[IX_BN] : opnd_mag_reg[IX_BD];
            end
            ST_MUL1: begin
                mul_a = opnd_mag_reg[IX_AD];
                mul_b = (op_reg == OP_MUL) ? opnd_mag_reg[IX_BD] : opnd_mag_reg[IX_BN];
            end
            default: begin
                mul_a = opnd_mag_reg[IX_AD];
                mul_b = opnd_mag_reg[IX_BD];
            end
        endcase
    end

    // operand select for the shared subtractor
    assign rem_shift = {rem_reg, q_reg[DW-1]};
    always_comb begin
        case (state_reg)
            ST_GCD: begin
                sub_a = {1'b0, gx_reg};
                sub_b = {1'b0, gy_reg};
            end
            ST_DIVN, ST_DIVD: begin
                sub_a = rem_shift;
                sub_b = {1'b0, g_reg};
            end
            default: begin
                sub_a = {1'b0, p0_reg};
                sub_b = {1'b0, p1_reg};
            end
        endcase
    end
    assign sub_neg = -sub_diff;

    rau_unit #(
        .WIDTH(WIDTH)
    ) u_unit (
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p),
        .sub_a     (sub_a),
        .sub_b     (sub_b),
        .sub_diff  (sub_diff),
        .sub_borrow(sub_borrow)
    );

    // signed combine of the cross products
    always_comb begin
        s0 = opnd_neg_reg[IX_AN]
            ^ ((op_reg == OP_MUL) ? opnd_neg_reg[IX_BN] : opnd_neg_reg[IX_BD]);
        s1 = (op_reg == OP_MUL) ? (opnd_neg_reg[IX_AD] ^ opnd_neg_reg[IX_BD])
            : (opnd_neg_reg[IX_AD] ^ opnd_neg_reg[IX_BN] ^ (op_reg == OP_SUB));
        comb_eq = (p0_reg == p1_reg) && (p0_reg == '0 || s0 == s1);
        case (op_reg)
            OP_ADD, OP_SUB: begin
                if (s0 == s1) begin
                    comb_n    = p0_reg + p1_reg;
                    comb_nneg = s0;
                end else begin
                    comb_n    = sub_borrow ? sub_neg[DW-1:0] : sub_diff[DW-1:0];
                    comb_nneg = sub_borrow ? s1 : s0;
                end
                comb_d    = p2_reg;
                comb_dneg = opnd_neg_reg[IX_AD] ^ opnd_neg_reg[IX_BD];
            end
            default: begin
                comb_n    = p0_reg;
                comb_nneg = s0;
                comb_d    = p1_reg;
                comb_dneg = s1;
            end
        endcase
    end

    // gcd and division helpers
    assign gcd_done = (gx_reg == '0) || (gy_reg == '0);
    assign gcd_g    = (gx_reg | gy_reg) << k_reg;
    assign div_q    = {q_reg[DW-2:0], !sub_borrow};
    assign div_rem  = sub_borrow ? rem_shift[DW-1:0] : sub_diff[DW-1:0];
    assign div_last = (cnt_reg == CNT_LAST);

    // range check of the reduced result
    assign fin_neg  = neg_reg && (n_reg != '0);
    assign fin_fits = (d_reg <= HALF - ONE) && (n_reg <= (fin_neg ? HALF : HALF - ONE));
    assign fin_num  = fin_neg ? (WIDTH)'(-n_reg[WIDTH-1:0]) : n_reg[WIDTH-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_bad || in_div0) begin
                        state_next = ST_DONE;
                    end else if (in_op == OP_NEG) begin
                        state_next = ST_GCD;
                    end else begin
                        state_next = ST_MUL0;
                    end
                end
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: begin
                state_next = (op_reg == OP_ADD || op_reg == OP_SUB) ? ST_MUL2 : ST_COMB;
            end
            ST_MUL2: state_next = ST_COMB;
            ST_COMB: begin
                state_next = (op_reg == OP_EQ || comb_d == '0) ? ST_DONE : ST_GCD;
            end
            ST_GCD: begin
                if (gcd_done) begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN: begin
                if (div_last) begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        opnd_mag_next    = opnd_mag_reg;
        opnd_neg_next    = opnd_neg_reg;
        op_next          = op_reg;
        p0_next          = p0_reg;
        p1_next          = p1_reg;
        p2_next          = p2_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        neg_next         = neg_reg;
        gx_next          = gx_reg;
        gy_next          = gy_reg;
        g_next           = g_reg;
        k_next           = k_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        pend_num_next    = pend_num_reg;
        pend_den_next    = pend_den_reg;
        pend_eq_next     = pend_eq_reg;
        pend_status_next = pend_status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    opnd_mag_next    = in_mag;
                    opnd_neg_next    = in_neg;
                    op_next          = in_op;
                    pend_num_next    = '0;
                    pend_den_next    = '0;
                    pend_eq_next     = 1'b0;
                    pend_status_next = (!in_bad && in_div0) ? STATUS_DIV0 : STATUS_OK;
                    // negate goes straight to reduction
                    n_next   = DW'(in_mag[IX_AN]);
                    d_next   = DW'(in_mag[IX_AD]);
                    neg_next = !in_neg[IX_AN] ^ in_neg[IX_AD];
                    gx_next  = DW'(in_mag[IX_AN]);
                    gy_next  = DW'(in_mag[IX_AD]);
                    k_next   = '0;
                end
            end
            ST_MUL0: p0_next = mul_p;
            ST_MUL1: p1_next = mul_p;
            ST_MUL2: p2_next = mul_p;
            ST_COMB: begin
                if (op_reg == OP_EQ) begin
                    pend_eq_next = comb_eq;
                end else if (comb_d == '0) begin
                    pend_status_next = STATUS_DIV0;
                end else begin
                    n_next   = comb_n;
                    d_next   = comb_d;
                    neg_next = comb_nneg ^ comb_dneg;
                    gx_next  = comb_n;
                    gy_next  = comb_d;
                    k_next   = '0;
                end
            end
            ST_GCD: begin
                // binary gcd, one step per cycle
                if (gcd_done) begin
                    g_next   = gcd_g;
                    q_next   = n_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end else if (!gx_reg[0] && !gy_reg[0]) begin
                    gx_next = gx_reg >> 1;
                    gy_next = gy_reg >> 1;
                    k_next  = k_reg + 1'b1;
                end else if (!gx_reg[0]) begin
                    gx_next = gx_reg >> 1;
                end else if (!gy_reg[0]) begin
                    gy_next = gy_reg >> 1;
                end else if (!sub_borrow) begin
                    gx_next = sub_diff[DW:1];
                end else begin
                    gy_next = sub_neg[DW:1];
                end
            end
            ST_DIVN: begin
                q_next   = div_q;
                rem_next = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    n_next   = div_q;
                    q_next   = d_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_DIVD: begin
                q_next   = div_q;
                rem_next = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    d_next = div_q;
                end
            end
            ST_FIN: begin
                if (fin_fits) begin
                    pend_num_next    = FIELD_W'(signed'(fin_num));
                    pend_den_next    = DEN_W'(d_reg[WIDTH-2:0]);
                    pend_status_next = STATUS_OK;
                end else begin
                    pend_status_next = STATUS_OVF;
                end
            end
            default: ;
        endcase
    end

    // output register
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({pend_status_reg, pend_eq_reg,
                                        pend_den_reg, pend_num_reg});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        opnd_mag_reg    <= opnd_mag_next;
        opnd_neg_reg    <= opnd_neg_next;
        op_reg          <= op_next;
        p0_reg          <= p0_next;
        p1_reg          <= p1_next;
        p2_reg          <= p2_next;
        n_reg           <= n_next;
        d_reg           <= d_next;
        neg_reg         <= neg_next;
        gx_reg          <= gx_next;
        gy_reg          <= gy_next;
        g_reg           <= g_next;
        k_reg           <= k_next;
        q_reg           <= q_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        pend_num_reg    <= pend_num_next;
        pend_den_reg    <= pend_den_next;
        pend_eq_reg     <= pend_eq_next;
        pend_status_reg <= pend_status_next;
        m_tdata_reg     <= m_tdata_next;
    end

    // checks
    `ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE, "block idle right after accepting an item")
    `ASSERT_ALWAYS(a_err_zero, aclk, aresetn, !m_tvalid_reg || m_tdata_reg[STATUS_LSB +: STATUS_W] == STATUS_OK || m_tdata_reg[STATUS_LSB-1:0] == '0, "error item with nonzero result fields")
    `ASSERT_ALWAYS(a_rem_below, aclk, aresetn, !(state_reg == ST_DIVN || state_reg == ST_DIVD) || rem_reg < g_reg, "division remainder not below divisor")
    `ASSERT_ALWAYS(a_gcd_live, aclk, aresetn, state_reg != ST_GCD || gx_reg != '0 || gy_reg != '0, "gcd operands both zero")

endmodule
